[hdl/manx2_pkg.sv]
`timescale 1ns / 1ps

package manx2_pkg;

    localparam int AD_PAD_BITS_DEF    = 64;
    localparam int AD_MAX_BITS_DEF    = 64;
    localparam int MIN_NONCE_BITS_DEF = 32;
    localparam int VARIABLE_AD_DEF    = 1;

    localparam logic [1:0] OP_NONCE   = 2'd0;
    localparam logic [1:0] OP_AD      = 2'd1;
    localparam logic [1:0] OP_MESSAGE = 2'd2;
    localparam logic [1:0] OP_ENCRYPT = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NONCE_SHORT = 2'd1;
    localparam logic [1:0] ST_MSG_LONG   = 2'd2;
    localparam logic [1:0] ST_AD_LONG    = 2'd3;

    localparam logic [1:0] REG_KEY_HIGH  = 2'd0;
    localparam logic [1:0] REG_KEY_LOW   = 2'd1;
    localparam logic [1:0] REG_NONCE_LEN = 2'd2;

    localparam logic [6:0] NONCE_LEN_RESET = 7'd96;
    localparam logic [8:0] BITS_ONE_BLOCK  = 9'd128;
    localparam logic [8:0] BITS_TWO_BLOCKS = 9'd256;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  word_index;
        logic [63:0] data_word;
        logic [6:0]  ad_bits;
        logic [7:0]  message_bits;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] cipher_word;
        logic [8:0]  cipher_bits;
        logic        last;
    } t_out_res;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                               input logic fin);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   m [16];
        logic [7:0]   a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) begin
            b[i] = s[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c+r] = SBOX[b[4*((c+r)%4)+r]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c];
            a1 = t[4*c+1];
            a2 = t[4*c+2];
            a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            m[4*c]   = fin ? a0 : (a0 ^ al ^ xtime(a0 ^ a1));
            m[4*c+1] = fin ? a1 : (a1 ^ al ^ xtime(a1 ^ a2));
            m[4*c+2] = fin ? a2 : (a2 ^ al ^ xtime(a2 ^ a3));
            m[4*c+3] = fin ? a3 : (a3 ^ al ^ xtime(a3 ^ a0));
        end
        for (int i = 0; i < 16; i++) begin
            o[127-8*i -: 8] = m[i];
        end
        return o ^ k;
    endfunction

    function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rcon);
        logic [7:0]   b [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++) begin
            b[i] = k[127-8*i -: 8];
        end
        b[0] = b[0] ^ SBOX[b[13]] ^ rcon;
        b[1] = b[1] ^ SBOX[b[14]];
        b[2] = b[2] ^ SBOX[b[15]];
        b[3] = b[3] ^ SBOX[b[12]];
        for (int i = 4; i < 16; i++) begin
            b[i] = b[i] ^ b[i-4];
        end
        for (int i = 0; i < 16; i++) begin
            o[127-8*i -: 8] = b[i];
        end
        return o;
    endfunction

endpackage

[hdl/manx2_aes128_encrypt_unit.sv]
`timescale 1ns / 1ps
// Channel   Direction  Signals
// in        request    i_in_valid, o_in_ready, i_in_data
// out       result     o_out_valid, i_out_ready, o_out_data
// cfg       request    i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
// A load request is taken while the unit is idle. An encrypt request is captured, then
// checked and formatted; each block then runs ten rounds of the shared AES round unit
// and is output as two words. A request that fails the checks returns one error word.
// Reset clears the sequencer, the key and sets the nonce length to 96.
// A stalled output holds the sequencer; no new request is taken until it drains.

module manx2_aes128_encrypt_unit
    import manx2_pkg::*;
#(
    parameter int AD_PAD_BITS    = AD_PAD_BITS_DEF,
    parameter int AD_MAX_BITS    = AD_MAX_BITS_DEF,
    parameter int MIN_NONCE_BITS = MIN_NONCE_BITS_DEF,
    parameter int VARIABLE_AD    = VARIABLE_AD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_res    o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FMT  = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_OUTH = 3'd3;
    localparam logic [2:0] S_OUTL = 3'd4;
    localparam logic [2:0] S_OUTE = 3'd5;

    logic [2:0]   r_state;
    logic [63:0]  r_key_hi, r_key_lo;
    logic [6:0]   r_nonce_len;
    logic [63:0]  r_nonce [2];
    logic [63:0]  r_ad;
    logic [63:0]  r_msg [4];
    t_in_req      r_req;
    logic [127:0] r_s, r_rk, r_blk2;
    logic [7:0]   r_rcon;
    logic [3:0]   r_round;
    logic         r_tiny, r_second;
    logic [1:0]   r_status;

    logic [127:0] key;
    logic [127:0] n_blk1, n_blk2, kn;
    logic [1:0]   n_status;
    logic         n_tiny;

    assign key         = {r_key_hi, r_key_lo};
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign kn          = key_next(r_rk, r_rcon);

    function automatic logic [127:0] top128(input logic [7:0] n);
        return ~({128{1'b1}} >> n);
    endfunction

    function automatic logic [255:0] top256(input logic [8:0] n);
        return ~({256{1'b1}} >> n);
    endfunction

    function automatic logic [127:0] bit_at(input logic [7:0] p);
        return {1'b1, 127'b0} >> p;
    endfunction

    always_comb begin
        int nl, al, ml, rr, cap2;
        logic [127:0] nn;
        logic [255:0] mm;
        logic [255:0] sh;
        logic [255:0] sh2;
        nl = int'(r_nonce_len);
        al = int'(r_req.ad_bits);
        ml = int'(r_req.message_bits);
        rr = 126 - AD_PAD_BITS - nl;
        cap2 = 126 - nl;
        nn = {r_nonce[0], r_nonce[1]};
        mm = {r_msg[0], r_msg[1], r_msg[2], r_msg[3]};
        sh2 = '0;
        if (nl < MIN_NONCE_BITS) begin
            n_status = ST_NONCE_SHORT;
        end else if (rr < 0 || ml >= cap2 + rr) begin
            n_status = ST_MSG_LONG;
        end else if (al > AD_MAX_BITS || ((VARIABLE_AD != 0) ? al >= AD_PAD_BITS
                                                              : al > AD_PAD_BITS)) begin
            n_status = ST_AD_LONG;
        end else begin
            n_status = ST_OK;
        end
        n_tiny = (ml <= rr);
        n_blk1 = nn & top128(8'(nl));
        n_blk1 = n_blk1 | (({r_ad, 64'b0} & top128(8'(al))) >> 8'(nl + 2));
        if (VARIABLE_AD != 0) begin
            n_blk1 = n_blk1 | bit_at(8'(nl + 2 + al));
        end
        n_blk2 = (nn & top128(8'(nl))) | bit_at(8'(nl + 1));
        if (n_tiny) begin
            n_blk1 = n_blk1 | bit_at(8'(nl));
            if (ml == rr) begin
                n_blk1 = n_blk1 | bit_at(8'(nl + 1));
            end else begin
                n_blk1 = n_blk1 | bit_at(8'(nl + 2 + AD_PAD_BITS + ml));
            end
            sh = (mm & top256(9'(ml))) >> 8'(nl + 2 + AD_PAD_BITS);
        end else begin
            sh = (mm & top256(9'(rr))) >> 8'(nl + 2 + AD_PAD_BITS);
            sh2 = ((mm << 8'(rr)) & top256(9'(ml - rr))) >> 8'(nl + 2);
            n_blk2 = n_blk2 | sh2[255:128];
            n_blk2 = n_blk2 | bit_at(8'(nl + 2 + ml - rr));
        end
        n_blk1 = n_blk1 | sh[255:128];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi    <= '0;
            r_key_lo    <= '0;
            r_nonce_len <= NONCE_LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KEY_HIGH:  r_key_hi    <= i_cfg_data;
                REG_KEY_LOW:   r_key_lo    <= i_cfg_data;
                REG_NONCE_LEN: r_nonce_len <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            case (i_in_data.opcode)
                OP_NONCE: begin
                    if (!i_in_data.word_index[1]) begin
                        r_nonce[i_in_data.word_index[0]] <= i_in_data.data_word;
                    end
                end
                OP_AD: begin
                    if (i_in_data.word_index == 2'd0) begin
                        r_ad <= i_in_data.data_word;
                    end
                end
                OP_MESSAGE: r_msg[i_in_data.word_index] <= i_in_data.data_word;
                default:    r_req <= i_in_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_in_data.opcode == OP_ENCRYPT) begin
                        r_state <= S_FMT;
                    end
                end
                S_FMT: begin
                    r_status <= n_status;
                    r_tiny   <= n_tiny;
                    r_blk2   <= n_blk2;
                    r_s      <= n_blk1 ^ key;
                    r_rk     <= key;
                    r_rcon   <= 8'h01;
                    r_round  <= 4'd1;
                    r_second <= 1'b0;
                    r_state  <= (n_status == ST_OK) ? S_RND : S_OUTE;
                end
                S_RND: begin
                    r_s     <= aes_round(r_s, kn, r_round == 4'd10);
                    r_rk    <= kn;
                    r_rcon  <= xtime(r_rcon);
                    r_round <= r_round + 4'd1;
                    if (r_round == 4'd10) begin
                        r_state <= S_OUTH;
                    end
                end
                S_OUTH: begin
                    if (i_out_ready) begin
                        r_state <= S_OUTL;
                    end
                end
                S_OUTL: begin
                    if (i_out_ready) begin
                        if (!r_tiny && !r_second) begin
                            r_s      <= r_blk2 ^ key;
                            r_rk     <= key;
                            r_rcon   <= 8'h01;
                            r_round  <= 4'd1;
                            r_second <= 1'b1;
                            r_state  <= S_RND;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_OUTE: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = (r_state == S_OUTH) || (r_state == S_OUTL) || (r_state == S_OUTE);

    always_comb begin
        o_out_data.status      = (r_state == S_OUTE) ? r_status : ST_OK;
        o_out_data.cipher_word = (r_state == S_OUTE) ? 64'd0 :
                                 (r_state == S_OUTH) ? r_s[127:64] : r_s[63:0];
        o_out_data.cipher_bits = (r_state == S_OUTE) ? 9'd0 :
                                 (r_tiny ? BITS_ONE_BLOCK : BITS_TWO_BLOCKS);
        o_out_data.last        = (r_state == S_OUTE) ||
                                 ((r_state == S_OUTL) && (r_tiny || r_second));
    end

endmodule

[hdl/manx2_checker.sv]
`timescale 1ns / 1ps

module manx2_checker
    import manx2_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_out_res o_out_data
);

    // A waiting result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    // The unit never takes a request while a result is pending.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("ready while result pending");

    // An error result is a single empty final word.
    a_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |->
            o_out_data.last && o_out_data.cipher_bits == 9'd0 &&
            o_out_data.cipher_word == 64'd0)
        else $error("malformed error result");

    // A good result reports one or two blocks.
    a_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_OK |->
            o_out_data.cipher_bits == BITS_ONE_BLOCK ||
            o_out_data.cipher_bits == BITS_TWO_BLOCKS)
        else $error("bad ciphertext length");

endmodule

bind manx2_aes128_encrypt_unit manx2_checker u_manx2_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
